FILE: rtl/assert_macros.svh
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is ignored while reset is asserted.
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define CHK_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/scpp_pkg.sv
package scpp_pkg;

    // Field widths.
    localparam int COORD_W = 12;
    localparam int SIDE_W  = 13;
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W  = FRAC_BITS + 1;
    localparam int OFFS_W  = 26;
    localparam int BYTE_W  = 8;

    // Largest side; wider register values saturate to it.
    localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(4096);

    // Unit value 1.0 in the fraction format.
    localparam logic [FRAC_W-1:0] Q_ONE = FRAC_W'(1 << FRAC_BITS);

    // Pattern constants, rounded half up.
    localparam logic [FRAC_W-1:0] Q_TINT = FRAC_W'(((92 << FRAC_BITS) + 50) / 100);
    localparam logic [FRAC_W-1:0] Q_A55  = FRAC_W'(((55 << FRAC_BITS) + 50) / 100);
    localparam logic [FRAC_W-1:0] Q_A35  = FRAC_W'(((35 << FRAC_BITS) + 50) / 100);
    localparam logic [FRAC_W-1:0] Q_A40  = FRAC_W'(((40 << FRAC_BITS) + 50) / 100);
    localparam logic [FRAC_W-1:0] Q_A30  = FRAC_W'(((30 << FRAC_BITS) + 50) / 100);
    localparam logic [FRAC_W-1:0] Q_A175 = FRAC_W'(((175 << FRAC_BITS) + 500) / 1000);
    localparam logic [FRAC_W-1:0] Q_LIT  = FRAC_W'(((62 << FRAC_BITS) + 50) / 100);
    localparam logic [FRAC_W-1:0] Q_DIM  = FRAC_W'(((18 << FRAC_BITS) + 50) / 100);
    localparam logic [FRAC_W-1:0] Q_DARK = FRAC_W'(((24 << FRAC_BITS) + 50) / 100);

    // Reciprocal of three for 11-bit values: floor(n/3) = (n*2731) >> 13.
    localparam logic [11:0] RECIP3 = 12'd2731;

    // Divider and square root pipeline shape.
    localparam int DIV_STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES = FRAC_BITS / DIV_STEPS_PER_STAGE;
    localparam int SQRT_STEPS = FRAC_W;
    localparam int SQRT_STEPS_PER_STAGE = 3;
    localparam int SQRT_STAGES =
        (SQRT_STEPS + SQRT_STEPS_PER_STAGE - 1) / SQRT_STEPS_PER_STAGE;
    localparam int RAD_W = 2 * FRAC_W;
    localparam int SREM_W = FRAC_W + 2;

    // Pipeline depth: input, setup, divider, two mix stages, root, output.
    localparam int NUM_STAGES = 2 + DIV_STAGES + 2 + SQRT_STAGES + 1;

    typedef enum logic [2:0] {
        MODE_COLOR     = 3'd0,
        MODE_DEPTH     = 3'd1,
        MODE_NORMALS   = 3'd2,
        MODE_ALBEDO    = 3'd3,
        MODE_SHADOW    = 3'd4,
        MODE_OCCLUSION = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_MODE   = 3'd2,
        CFG_RED    = 3'd3,
        CFG_GREEN  = 3'd4,
        CFG_BLUE   = 3'd5,
        CFG_ALPHA  = 3'd6,
        CFG_PARITY = 3'd7
    } cfg_idx_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [SIDE_W-1:0]  w;
        logic [SIDE_W-1:0]  h;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        mode_t              mode;
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  blue;
        logic               parity;
    } cfg_t;

    // Per-pixel facts that travel down the whole pipe.
    typedef struct packed {
        logic              outside;
        logic [OFFS_W-1:0] offset;
        logic              lit6;
        logic              full8;
    } info_t;

    typedef struct packed {
        logic [FRAC_W-1:0]  quo;
        logic [COORD_W-1:0] rem;
    } div_state_t;

    typedef struct packed {
        info_t      info;
        div_state_t dx;
        div_state_t dy;
    } frac_t;

    typedef struct packed {
        info_t             info;
        logic [FRAC_W-1:0] ur;
        logic [FRAC_W-1:0] ug;
        logic [FRAC_W-1:0] ub;
        logic [BYTE_W-1:0] cr;
        logic [BYTE_W-1:0] cg;
        logic [BYTE_W-1:0] cb;
        logic [RAD_W-1:0]  sq_sum;
    } mix_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [SREM_W-1:0] rem;
        logic [FRAC_W-1:0] root;
    } root_t;

    typedef struct packed {
        info_t             info;
        logic [FRAC_W-1:0] ur;
        logic [FRAC_W-1:0] ug;
        logic [FRAC_W-1:0] ub;
        logic [BYTE_W-1:0] cr;
        logic [BYTE_W-1:0] cg;
        logic [BYTE_W-1:0] cb;
        root_t             sq;
    } prep_t;

    // Unit value to byte: round(255*u) with half up, u clamped to 1.0.
    function automatic logic [BYTE_W-1:0] to_byte(input logic [FRAC_W-1:0] u);
        logic [FRAC_W-1:0] uc;
        logic [24:0]       prod;
        begin
            uc = (u > Q_ONE) ? Q_ONE : u;
            prod = {uc, 8'b0} - 25'(uc) + 25'(1 << (FRAC_BITS - 1));
            return prod[FRAC_BITS +: BYTE_W];
        end
    endfunction

    // One restoring division step: shift in a zero, subtract when it fits.
    function automatic div_state_t div_step(input div_state_t s,
                                            input logic [COORD_W-1:0] d);
        logic [COORD_W:0] r2;
        div_state_t       n;
        begin
            r2 = {s.rem, 1'b0};
            if (r2 >= {1'b0, d}) begin
                n.rem = COORD_W'(r2 - {1'b0, d});
                n.quo = {s.quo[FRAC_W-2:0], 1'b1};
            end else begin
                n.rem = r2[COORD_W-1:0];
                n.quo = {s.quo[FRAC_W-2:0], 1'b0};
            end
            return n;
        end
    endfunction

    // One digit of the square root: take two radicand bits per step.
    function automatic root_t sqrt_step(input root_t s);
        logic [SREM_W+1:0] rem4;
        logic [SREM_W+1:0] trial;
        root_t             n;
        begin
            rem4  = {s.rem, s.rad[RAD_W-1 -: 2]};
            trial = (SREM_W + 2)'({s.root, 2'b01});
            n.rad = {s.rad[RAD_W-3:0], 2'b00};
            if (rem4 >= trial) begin
                n.rem  = SREM_W'(rem4 - trial);
                n.root = {s.root[FRAC_W-2:0], 1'b1};
            end else begin
                n.rem  = SREM_W'(rem4);
                n.root = {s.root[FRAC_W-2:0], 1'b0};
            end
            return n;
        end
    endfunction

endpackage

FILE: rtl/synthetic_capture_pattern_pixel.sv
// Test-pattern pixel generator for an RGBA8 capture buffer.
// Input channel s_*: one pixel coordinate per item (s_pixel_x, s_pixel_y).
// Result channel m_*: the RGBA bytes of that pixel, its byte offset
// y*4*width + x*4 and an outside flag for coordinates beyond the size.
// Configuration channel cfg_*: cfg_index selects width, height, mode, the
// clear color bytes, alpha and frame parity; cfg_ready is always high and
// writes are meant to happen while no item is in flight.
// Throughput is one item per cycle while m_ready stays high. An accepted item
// reaches m_valid through fifteen registers: input register, setup multiply,
// four divider stages of four quotient bits each, two mix stages, six square
// root stages of up to three digits each, and the output register.
// Each stage holds its own valid bit and advances whenever the next stage is
// empty or moving, so a stalled receiver only holds the items that have
// caught up behind the output; empty stages keep filling and s_ready drops
// only once the whole pipe is full.
// Reset empties the pipe and restores width 1, height 1, color mode, black
// clear color, alpha 255 and parity 0.
module synthetic_capture_pattern_pixel (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [scpp_pkg::SIDE_W-1:0]   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [scpp_pkg::COORD_W-1:0]  s_pixel_x,
    input  logic [scpp_pkg::COORD_W-1:0]  s_pixel_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [scpp_pkg::BYTE_W-1:0]   m_red,
    output logic [scpp_pkg::BYTE_W-1:0]   m_green,
    output logic [scpp_pkg::BYTE_W-1:0]   m_blue,
    output logic [scpp_pkg::BYTE_W-1:0]   m_alpha,
    output logic [scpp_pkg::OFFS_W-1:0]   m_byte_offset,
    output logic                          m_outside
);

    localparam int NS = scpp_pkg::NUM_STAGES;
    localparam int DIV0 = 2;
    localparam int MIX0 = DIV0 + scpp_pkg::DIV_STAGES;
    localparam int SQ0 = MIX0 + 2;
    localparam int LAST = NS - 1;

    logic [scpp_pkg::SIDE_W-1:0]  width_reg;
    logic [scpp_pkg::SIDE_W-1:0]  height_reg;
    scpp_pkg::mode_t              mode_reg;
    logic [scpp_pkg::BYTE_W-1:0]  red_cfg_reg;
    logic [scpp_pkg::BYTE_W-1:0]  green_cfg_reg;
    logic [scpp_pkg::BYTE_W-1:0]  blue_cfg_reg;
    logic [scpp_pkg::BYTE_W-1:0]  alpha_cfg_reg;
    logic                         parity_reg;

    logic [NS-1:0]                vld_reg;
    logic [NS-1:0]                adv;
    logic [scpp_pkg::COORD_W-1:0] x_reg;
    logic [scpp_pkg::COORD_W-1:0] y_reg;
    scpp_pkg::cfg_t               cfg;

    scpp_pkg::frac_t              frac_pipe [scpp_pkg::DIV_STAGES+1];
    scpp_pkg::prep_t              root_pipe [scpp_pkg::SQRT_STAGES+1];

    assign cfg_ready = 1'b1;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= scpp_pkg::SIDE_W'(1);
            height_reg    <= scpp_pkg::SIDE_W'(1);
            mode_reg      <= scpp_pkg::MODE_COLOR;
            red_cfg_reg   <= '0;
            green_cfg_reg <= '0;
            blue_cfg_reg  <= '0;
            alpha_cfg_reg <= '1;
            parity_reg    <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (scpp_pkg::cfg_idx_t'(cfg_index))
                scpp_pkg::CFG_WIDTH:  width_reg     <= cfg_data;
                scpp_pkg::CFG_HEIGHT: height_reg    <= cfg_data;
                scpp_pkg::CFG_MODE:   mode_reg      <= scpp_pkg::mode_t'(cfg_data[2:0]);
                scpp_pkg::CFG_RED:    red_cfg_reg   <= cfg_data[scpp_pkg::BYTE_W-1:0];
                scpp_pkg::CFG_GREEN:  green_cfg_reg <= cfg_data[scpp_pkg::BYTE_W-1:0];
                scpp_pkg::CFG_BLUE:   blue_cfg_reg  <= cfg_data[scpp_pkg::BYTE_W-1:0];
                scpp_pkg::CFG_ALPHA:  alpha_cfg_reg <= cfg_data[scpp_pkg::BYTE_W-1:0];
                scpp_pkg::CFG_PARITY: parity_reg    <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Saturated sides and the fraction divisors derived from them.
    always_comb begin
        cfg.w      = (width_reg > scpp_pkg::MAX_SIDE) ? scpp_pkg::MAX_SIDE : width_reg;
        cfg.h      = (height_reg > scpp_pkg::MAX_SIDE) ? scpp_pkg::MAX_SIDE : height_reg;
        cfg.dx     = (cfg.w > scpp_pkg::SIDE_W'(1)) ? scpp_pkg::COORD_W'(cfg.w - 1'b1)
                                                    : scpp_pkg::COORD_W'(1);
        cfg.dy     = (cfg.h > scpp_pkg::SIDE_W'(1)) ? scpp_pkg::COORD_W'(cfg.h - 1'b1)
                                                    : scpp_pkg::COORD_W'(1);
        cfg.mode   = mode_reg;
        cfg.red    = red_cfg_reg;
        cfg.green  = green_cfg_reg;
        cfg.blue   = blue_cfg_reg;
        cfg.parity = parity_reg;
    end

    // A stage may load when it is empty or its item moves on this cycle.
    always_comb begin
        adv[LAST] = !vld_reg[LAST] || m_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[0];
    assign m_valid = vld_reg[LAST];

    // Valid bits travel with the items.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            x_reg <= s_pixel_x;
            y_reg <= s_pixel_y;
        end
    end

    scpp_setup u_setup (
        .aclk  (aclk),
        .en    (adv[1]),
        .cfg   (cfg),
        .pix_x (x_reg),
        .pix_y (y_reg),
        .q_reg (frac_pipe[0])
    );

    for (genvar i = 0; i < scpp_pkg::DIV_STAGES; i++) begin : g_div
        scpp_div_stage u_div (
            .aclk  (aclk),
            .en    (adv[DIV0+i]),
            .cfg   (cfg),
            .d_in  (frac_pipe[i]),
            .q_reg (frac_pipe[i+1])
        );
    end

    scpp_mix u_mix (
        .aclk  (aclk),
        .en    (adv[MIX0+1:MIX0]),
        .cfg   (cfg),
        .d_in  (frac_pipe[scpp_pkg::DIV_STAGES]),
        .q_reg (root_pipe[0])
    );

    for (genvar j = 0; j < scpp_pkg::SQRT_STAGES; j++) begin : g_sqrt
        scpp_sqrt_stage #(
            .STEP_BASE (j * scpp_pkg::SQRT_STEPS_PER_STAGE)
        ) u_sqrt (
            .aclk  (aclk),
            .en    (adv[SQ0+j]),
            .d_in  (root_pipe[j]),
            .q_reg (root_pipe[j+1])
        );
    end

    scpp_pack u_pack (
        .aclk        (aclk),
        .en          (adv[LAST]),
        .cfg         (cfg),
        .alpha_value (alpha_cfg_reg),
        .d_in        (root_pipe[scpp_pkg::SQRT_STAGES]),
        .red_reg     (m_red),
        .green_reg   (m_green),
        .blue_reg    (m_blue),
        .alpha_reg   (m_alpha),
        .offset_reg  (m_byte_offset),
        .outside_reg (m_outside)
    );

endmodule

FILE: rtl/scpp_setup.sv
module scpp_setup (
    input  logic                          aclk,
    input  logic                          en,
    input  scpp_pkg::cfg_t                cfg,
    input  logic [scpp_pkg::COORD_W-1:0]  pix_x,
    input  logic [scpp_pkg::COORD_W-1:0]  pix_y,
    output scpp_pkg::frac_t               q_reg
);

    scpp_pkg::frac_t q_next;
    logic [24:0] row_base;
    logic [22:0] x_third;
    logic [22:0] y_third;
    logic        x_eq;
    logic        y_eq;

    // Range check, buffer offset, checker phases and divider start values.
    always_comb begin
        row_base = 25'(pix_y) * 25'(cfg.w);
        x_third  = 23'(pix_x[scpp_pkg::COORD_W-1:1]) * 23'(scpp_pkg::RECIP3);
        y_third  = 23'(pix_y[scpp_pkg::COORD_W-1:1]) * 23'(scpp_pkg::RECIP3);
        x_eq     = (pix_x == cfg.dx);
        y_eq     = (pix_y == cfg.dy);

        q_next.info.outside = ({1'b0, pix_x} >= cfg.w) || ({1'b0, pix_y} >= cfg.h);
        q_next.info.offset  = scpp_pkg::OFFS_W'({row_base + 25'(pix_x), 2'b00});
        q_next.info.lit6    = ~(x_third[13] ^ y_third[13] ^ cfg.parity);
        q_next.info.full8   = ~(pix_x[3] ^ pix_y[3] ^ cfg.parity);

        // A coordinate on the last row or column gives exactly 1.0.
        q_next.dx.quo = scpp_pkg::FRAC_W'(x_eq);
        q_next.dx.rem = x_eq ? '0 : pix_x;
        q_next.dy.quo = scpp_pkg::FRAC_W'(y_eq);
        q_next.dy.rem = y_eq ? '0 : pix_y;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

endmodule

FILE: rtl/scpp_div_stage.sv
module scpp_div_stage (
    input  logic            aclk,
    input  logic            en,
    input  scpp_pkg::cfg_t  cfg,
    input  scpp_pkg::frac_t d_in,
    output scpp_pkg::frac_t q_reg
);

    scpp_pkg::frac_t q_next;

    // A few quotient bits of both coordinate fractions per stage.
    always_comb begin
        q_next = d_in;
        for (int i = 0; i < scpp_pkg::DIV_STEPS_PER_STAGE; i++) begin
            q_next.dx = scpp_pkg::div_step(q_next.dx, cfg.dx);
            q_next.dy = scpp_pkg::div_step(q_next.dy, cfg.dy);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

endmodule

FILE: rtl/scpp_mix.sv
module scpp_mix (
    input  logic            aclk,
    input  logic [1:0]      en,
    input  scpp_pkg::cfg_t  cfg,
    input  scpp_pkg::frac_t d_in,
    output scpp_pkg::prep_t q_reg
);

    localparam int FW = scpp_pkg::FRAC_W;
    localparam int FB = scpp_pkg::FRAC_BITS;

    scpp_pkg::mix_t  mix_reg;
    scpp_pkg::mix_t  mix_next;
    scpp_pkg::prep_t q_next;

    logic [FW-1:0]   fx;
    logic [FW-1:0]   fy;
    logic [FW:0]     fx2;
    logic [FW:0]     fy2;
    logic [FW-1:0]   ax;
    logic [FW-1:0]   ay;
    logic [2*FW-1:0] p_r;
    logic [2*FW-1:0] p_g;
    logic [2*FW:0]   p_b;
    logic [2*FW-1:0] p_dark;
    logic [FW-1:0]   base;
    logic [24:0]     t_r;
    logic [24:0]     t_g;
    logic [24:0]     t_b;
    logic [FW:0]     s_wide;
    logic [FW-1:0]   s_cap;

    // Products and per-mode unit values from the two fractions.
    always_comb begin
        fx  = d_in.dx.quo;
        fy  = d_in.dy.quo;
        fx2 = {fx, 1'b0};
        fy2 = {fy, 1'b0};
        ax  = (fx2 >= (FW + 1)'(scpp_pkg::Q_ONE)) ? FW'(fx2 - (FW + 1)'(scpp_pkg::Q_ONE))
                                                  : FW'((FW + 1)'(scpp_pkg::Q_ONE) - fx2);
        ay  = (fy2 >= (FW + 1)'(scpp_pkg::Q_ONE)) ? FW'(fy2 - (FW + 1)'(scpp_pkg::Q_ONE))
                                                  : FW'((FW + 1)'(scpp_pkg::Q_ONE) - fy2);
        p_r    = (2 * FW)'(fx) * (2 * FW)'(scpp_pkg::Q_A35);
        p_g    = (2 * FW)'(fy) * (2 * FW)'(scpp_pkg::Q_A40);
        p_b    = (2 * FW + 1)'((FW + 1)'(fx) + (FW + 1)'(fy)) * (2 * FW + 1)'(scpp_pkg::Q_A175);
        p_dark = (2 * FW)'(fy) * (2 * FW)'(scpp_pkg::Q_DARK);
        base   = d_in.info.lit6 ? scpp_pkg::Q_LIT : scpp_pkg::Q_DIM;
        t_r    = 25'(cfg.red) * 25'(scpp_pkg::Q_TINT) + 25'(1 << (FB - 1));
        t_g    = 25'(cfg.green) * 25'(scpp_pkg::Q_TINT) + 25'(1 << (FB - 1));
        t_b    = 25'(cfg.blue) * 25'(scpp_pkg::Q_TINT) + 25'(1 << (FB - 1));

        mix_next.info   = d_in.info;
        mix_next.sq_sum = (2 * FW)'(ax) * (2 * FW)'(ax) + (2 * FW)'(ay) * (2 * FW)'(ay);
        mix_next.cr     = d_in.info.full8 ? cfg.red   : t_r[FB +: 8];
        mix_next.cg     = d_in.info.full8 ? cfg.green : t_g[FB +: 8];
        mix_next.cb     = d_in.info.full8 ? cfg.blue  : t_b[FB +: 8];
        mix_next.ur     = '0;
        mix_next.ug     = '0;
        mix_next.ub     = '0;

        case (cfg.mode) inside
            scpp_pkg::MODE_DEPTH: begin
                mix_next.ur = scpp_pkg::Q_ONE - fy;
                mix_next.ug = scpp_pkg::Q_ONE - fy;
                mix_next.ub = scpp_pkg::Q_ONE - fy;
            end
            scpp_pkg::MODE_NORMALS: begin
                mix_next.ur = fx;
                mix_next.ug = scpp_pkg::Q_ONE - fy;
            end
            scpp_pkg::MODE_ALBEDO: begin
                mix_next.ur = FW'((FW + 1)'(scpp_pkg::Q_A55) + p_r[2*FW-1:FB]);
                mix_next.ug = FW'((FW + 1)'(scpp_pkg::Q_A40) + p_g[2*FW-1:FB]);
                mix_next.ub = FW'((FW + 2)'(scpp_pkg::Q_A30) + p_b[2*FW:FB]);
            end
            scpp_pkg::MODE_SHADOW, scpp_pkg::MODE_OCCLUSION: begin
                if ((FW + 1)'(base) > p_dark[2*FW-1:FB]) begin
                    mix_next.ur = FW'((FW + 1)'(base) - p_dark[2*FW-1:FB]);
                end
                mix_next.ug = mix_next.ur;
                mix_next.ub = mix_next.ur;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            mix_reg <= mix_next;
        end
    end

    // Squared length of the in-plane normal, capped at 1.0, sets the root radicand.
    always_comb begin
        s_wide = mix_reg.sq_sum[2*FW-1:FB];
        s_cap  = (s_wide > (FW + 1)'(scpp_pkg::Q_ONE)) ? scpp_pkg::Q_ONE : FW'(s_wide);

        q_next.info    = mix_reg.info;
        q_next.ur      = mix_reg.ur;
        q_next.ug      = mix_reg.ug;
        q_next.ub      = mix_reg.ub;
        q_next.cr      = mix_reg.cr;
        q_next.cg      = mix_reg.cg;
        q_next.cb      = mix_reg.cb;
        q_next.sq.rad  = scpp_pkg::RAD_W'({scpp_pkg::Q_ONE - s_cap, {FB{1'b0}}});
        q_next.sq.rem  = '0;
        q_next.sq.root = '0;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            q_reg <= q_next;
        end
    end

endmodule

FILE: rtl/scpp_sqrt_stage.sv
module scpp_sqrt_stage #(
    parameter int STEP_BASE = 0
) (
    input  logic            aclk,
    input  logic            en,
    input  scpp_pkg::prep_t d_in,
    output scpp_pkg::prep_t q_reg
);

    scpp_pkg::prep_t q_next;

    // A few root digits per stage; the last stage may have fewer to do.
    always_comb begin
        q_next = d_in;
        for (int i = 0; i < scpp_pkg::SQRT_STEPS_PER_STAGE; i++) begin
            if (STEP_BASE + i < scpp_pkg::SQRT_STEPS) begin
                q_next.sq = scpp_pkg::sqrt_step(q_next.sq);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

endmodule

FILE: rtl/scpp_pack.sv
module scpp_pack (
    input  logic                          aclk,
    input  logic                          en,
    input  scpp_pkg::cfg_t                cfg,
    input  logic [scpp_pkg::BYTE_W-1:0]   alpha_value,
    input  scpp_pkg::prep_t               d_in,
    output logic [scpp_pkg::BYTE_W-1:0]   red_reg,
    output logic [scpp_pkg::BYTE_W-1:0]   green_reg,
    output logic [scpp_pkg::BYTE_W-1:0]   blue_reg,
    output logic [scpp_pkg::BYTE_W-1:0]   alpha_reg,
    output logic [scpp_pkg::OFFS_W-1:0]   offset_reg,
    output logic                          outside_reg
);

    logic [scpp_pkg::BYTE_W-1:0] red_next;
    logic [scpp_pkg::BYTE_W-1:0] green_next;
    logic [scpp_pkg::BYTE_W-1:0] blue_next;

    // Final byte encoding per mode; an outside pixel reads as all zero.
    always_comb begin
        case (cfg.mode) inside
            scpp_pkg::MODE_DEPTH, scpp_pkg::MODE_ALBEDO,
            scpp_pkg::MODE_SHADOW, scpp_pkg::MODE_OCCLUSION: begin
                red_next   = scpp_pkg::to_byte(d_in.ur);
                green_next = scpp_pkg::to_byte(d_in.ug);
                blue_next  = scpp_pkg::to_byte(d_in.ub);
            end
            scpp_pkg::MODE_NORMALS: begin
                red_next   = scpp_pkg::to_byte(d_in.ur);
                green_next = scpp_pkg::to_byte(d_in.ug);
                blue_next  = scpp_pkg::to_byte(d_in.sq.root);
            end
            default: begin
                red_next   = d_in.cr;
                green_next = d_in.cg;
                blue_next  = d_in.cb;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg     <= d_in.info.outside ? '0 : red_next;
            green_reg   <= d_in.info.outside ? '0 : green_next;
            blue_reg    <= d_in.info.outside ? '0 : blue_next;
            alpha_reg   <= d_in.info.outside ? '0 : alpha_value;
            offset_reg  <= d_in.info.outside ? '0 : d_in.info.offset;
            outside_reg <= d_in.info.outside;
        end
    end

endmodule

FILE: rtl/scpp_checker.sv
`include "assert_macros.svh"

module scpp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [2:0]                    cfg_index,
    input logic [scpp_pkg::SIDE_W-1:0]   cfg_data,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [scpp_pkg::BYTE_W-1:0]   m_red,
    input logic [scpp_pkg::BYTE_W-1:0]   m_green,
    input logic [scpp_pkg::BYTE_W-1:0]   m_blue,
    input logic [scpp_pkg::BYTE_W-1:0]   m_alpha,
    input logic [scpp_pkg::OFFS_W-1:0]   m_byte_offset,
    input logic                          m_outside
);

    logic [scpp_pkg::BYTE_W-1:0] alpha_reg;
    logic                        payload_zero;

    // Mirror of the alpha register as written through the port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= '1;
        end else if (cfg_valid && cfg_ready &&
                     cfg_index == scpp_pkg::CFG_ALPHA) begin
            alpha_reg <= cfg_data[scpp_pkg::BYTE_W-1:0];
        end
    end

    // All color bytes and the offset are zero.
    assign payload_zero = (m_red == '0) && (m_green == '0) && (m_blue == '0) &&
                          (m_alpha == '0) && (m_byte_offset == '0);

    // An outside pixel carries no color and no offset.
    `CHK_ASSERT(a_outside_zero, aclk, aresetn, m_valid && m_outside |-> payload_zero, "outside item has nonzero payload")

    // Every pixel inside the frame carries the configured alpha.
    `CHK_ASSERT(a_alpha_match, aclk, aresetn, m_valid && !m_outside |-> m_alpha == alpha_reg, "alpha differs")

    // Reset empties the pipe.
    `CHK_ASSERT_NORST(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid right after reset")

    // A stalled result holds its place.
    `CHK_ASSERT(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_byte_offset), "stalled result changed")

endmodule

bind synthetic_capture_pattern_pixel scpp_checker u_scpp_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

// One expected pixel result.
typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [25:0] offset;
    logic        outside;
} pixel_t;

// Predicts pattern pixels and checks the results in order.
class pixel_scoreboard;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  mode_reg;
    logic [7:0]  clr_r;
    logic [7:0]  clr_g;
    logic [7:0]  clr_b;
    logic [7:0]  alpha_reg;
    logic        parity_reg;
    pixel_t      pending_px[$];
    int          mismatches;
    int          checked;
    int          outside_seen;

    function new();
        width_reg = 13'd1;
        height_reg = 13'd1;
        mode_reg = scpp_pkg::MODE_COLOR;
        clr_r = 8'd0;
        clr_g = 8'd0;
        clr_b = 8'd0;
        alpha_reg = 8'd255;
        parity_reg = 1'b0;
        mismatches = 0;
        checked = 0;
        outside_seen = 0;
    endfunction

    function void write_reg(scpp_pkg::cfg_idx_t idx, logic [12:0] val);
        case (idx)
            scpp_pkg::CFG_WIDTH: width_reg = val;
            scpp_pkg::CFG_HEIGHT: height_reg = val;
            scpp_pkg::CFG_MODE: mode_reg = val[2:0];
            scpp_pkg::CFG_RED: clr_r = val[7:0];
            scpp_pkg::CFG_GREEN: clr_g = val[7:0];
            scpp_pkg::CFG_BLUE: clr_b = val[7:0];
            scpp_pkg::CFG_ALPHA: alpha_reg = val[7:0];
            scpp_pkg::CFG_PARITY: parity_reg = val[0];
            default: ;
        endcase
    endfunction

    // Rounded Q16 constant n/d.
    function longint qconst(longint n, longint d);
        return ((n << 16) + d / 2) / d;
    endfunction

    function logic [7:0] unit_byte(longint f);
        longint u;
        if (f <= 0) return 8'd0;
        u = (f > 65536) ? 65536 : f;
        return 8'((u * 255 + 32768) >> 16);
    endfunction

    function longint coord_frac(longint v, longint side);
        longint d;
        longint q;
        d = (side > 1) ? side - 1 : 1;
        q = (v << 16) / d;
        return (q > 65536) ? 65536 : q;
    endfunction

    function longint int_sqrt(longint n);
        longint r;
        longint t;
        r = 0;
        for (int b = 17; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    function logic [7:0] tint(logic [7:0] c, bit full);
        if (full) return c;
        return 8'((longint'(c) * qconst(92, 100) + 32768) >> 16);
    endfunction

    // Work out the pixel for one accepted coordinate.
    function void note_pixel(logic [11:0] px, logic [11:0] py);
        pixel_t p;
        longint x, y, w, h, fx, fy, nx, ny, s, base, dark;
        bit     sel;
        x = px;
        y = py;
        w = (width_reg > 4096) ? 4096 : width_reg;
        h = (height_reg > 4096) ? 4096 : height_reg;
        p = '{default: 0};
        if (x >= w || y >= h) begin
            p.outside = 1'b1;
        end else begin
            fx = coord_frac(x, w);
            fy = coord_frac(y, h);
            case (mode_reg)
                scpp_pkg::MODE_DEPTH: begin
                    p.red = unit_byte(65536 - fy);
                    p.green = p.red;
                    p.blue = p.red;
                end
                scpp_pkg::MODE_NORMALS: begin
                    nx = 2 * fx - 65536;
                    ny = 2 * fy - 65536;
                    s = (nx * nx + ny * ny) >> 16;
                    if (s > 65536) s = 65536;
                    p.red = unit_byte(fx);
                    p.green = unit_byte(65536 - fy);
                    p.blue = unit_byte(int_sqrt((65536 - s) << 16));
                end
                scpp_pkg::MODE_ALBEDO: begin
                    p.red = unit_byte(qconst(55, 100) + ((fx * qconst(35, 100)) >> 16));
                    p.green = unit_byte(qconst(40, 100) + ((fy * qconst(40, 100)) >> 16));
                    p.blue = unit_byte(qconst(30, 100)
                                       + (((fx + fy) * qconst(175, 1000)) >> 16));
                end
                scpp_pkg::MODE_SHADOW, scpp_pkg::MODE_OCCLUSION: begin
                    sel = (((x / 6) + (y / 6) + parity_reg) % 2) == 0;
                    base = sel ? qconst(62, 100) : qconst(18, 100);
                    dark = (fy * qconst(24, 100)) >> 16;
                    p.red = unit_byte(base > dark ? base - dark : 0);
                    p.green = p.red;
                    p.blue = p.red;
                end
                default: begin
                    sel = (((x >> 3) + (y >> 3) + parity_reg) % 2) == 0;
                    p.red = tint(clr_r, sel);
                    p.green = tint(clr_g, sel);
                    p.blue = tint(clr_b, sel);
                end
            endcase
            p.alpha = alpha_reg;
            p.offset = 26'((y * w + x) * 4);
        end
        pending_px.push_back(p);
    endfunction

    // Compare one delivered pixel with the oldest prediction.
    function void check_pixel(pixel_t got);
        pixel_t e;
        checked++;
        if (got.outside) outside_seen++;
        if (pending_px.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pixel result");
            return;
        end
        e = pending_px.pop_front();
        if (got != e) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp %h %h %h %h %h %b, got %h %h %h %h %h %b",
                         e.red, e.green, e.blue, e.alpha, e.offset, e.outside,
                         got.red, got.green, got.blue, got.alpha, got.offset, got.outside);
        end
    endfunction
endclass

module tb_top;
    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [11:0] s_pixel_x;
    logic [11:0] s_pixel_y;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_red;
    logic [7:0]  m_green;
    logic [7:0]  m_blue;
    logic [7:0]  m_alpha;
    logic [25:0] m_byte_offset;
    logic        m_outside;

    pixel_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int quiet_cycles;
    int items_sent;

    synthetic_capture_pattern_pixel u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pixel_x(s_pixel_x), .s_pixel_y(s_pixel_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red(m_red), .m_green(m_green), .m_blue(m_blue), .m_alpha(m_alpha),
        .m_byte_offset(m_byte_offset), .m_outside(m_outside)
    );

    // Clock with a 10 ns period.
    initial aclk = 0;
    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // Receiver readiness; a pending hold keeps it low for a long stretch.
    initial begin
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom % 100) >= recv_idle_pct;
            end
        end
    end

    // Result check and watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_pixel('{m_red, m_green, m_blue, m_alpha, m_byte_offset, m_outside});
            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 5000) begin
                $display("timeout");
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic write_reg(scpp_pkg::cfg_idx_t idx, logic [12:0] val);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    // Offer one coordinate item, with random gaps in front of it.
    task automatic send_pixel(logic [11:0] x, logic [11:0] y);
        @(negedge aclk);
        while (($urandom % 100) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_pixel_x <= x;
        s_pixel_y <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_pixel(x, y);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 0;
        while (sb.pending_px.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        int w, h, wc, hc, x, y;
        sb = new();
        aresetn = 0;
        cfg_valid = 0;
        cfg_index = scpp_pkg::CFG_WIDTH;
        cfg_data = 0;
        s_valid = 0;
        s_pixel_x = 0;
        s_pixel_y = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        items_sent = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Items straight after reset use the reset settings.
        send_pixel(0, 0);
        send_pixel(1, 0);
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            if (ph < 6) begin
                send_idle_pct = 32;
                recv_idle_pct = 57;
            end else if (ph < 11) begin
                send_idle_pct = 57;
                recv_idle_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Sizes: full, one pixel, zero width, oversize, 4096 by 2, then random.
            case (ph)
                0: begin w = 4096; h = 4096; end
                1: begin w = 1; h = 1; end
                2: begin w = 0; h = 5; end
                3: begin w = 8191; h = 3000; end
                4: begin w = 4096; h = 2; end
                default: begin
                    w = ($urandom % 2) ? $urandom_range(2, 64) : $urandom_range(1, 4096);
                    h = ($urandom % 2) ? $urandom_range(2, 64) : $urandom_range(1, 4096);
                end
            endcase
            write_reg(scpp_pkg::CFG_WIDTH, 13'(w));
            write_reg(scpp_pkg::CFG_HEIGHT, 13'(h));
            write_reg(scpp_pkg::CFG_MODE, 13'(ph % 8));
            write_reg(scpp_pkg::CFG_RED,
                      (ph == 0) ? 13'd255 : (ph == 1) ? 13'd0 : 13'($urandom % 256));
            write_reg(scpp_pkg::CFG_GREEN,
                      (ph == 0) ? 13'd255 : (ph == 1) ? 13'd0 : 13'($urandom % 256));
            write_reg(scpp_pkg::CFG_BLUE,
                      (ph == 0) ? 13'd255 : (ph == 1) ? 13'd0 : 13'($urandom % 256));
            write_reg(scpp_pkg::CFG_ALPHA, (ph == 1) ? 13'd0 : 13'($urandom % 256));
            write_reg(scpp_pkg::CFG_PARITY, 13'((ph / 8) % 2));
            wc = (w > 4096) ? 4096 : w;
            hc = (h > 4096) ? 4096 : h;

            // Pressure: the receiver stalls while items keep coming.
            if (ph == 12) hold_cycles = 300;

            // Corners, the first pixels past each edge, the far corner and the center.
            send_pixel(0, 0);
            send_pixel(12'(wc > 0 ? wc - 1 : 0), 12'(hc > 0 ? hc - 1 : 0));
            send_pixel(12'(wc), 0);
            send_pixel(0, 12'(hc));
            send_pixel(12'hFFF, 12'hFFF);
            send_pixel(12'(wc / 2), 12'(hc / 2));

            // Random coordinates, mostly inside the image.
            for (int i = 0; i < 41; i++) begin
                if (($urandom % 10) < 7 && wc > 0 && hc > 0) begin
                    x = $urandom_range(0, wc - 1);
                    y = $urandom_range(0, hc - 1);
                end else begin
                    x = $urandom % 4096;
                    y = $urandom % 4096;
                end
                send_pixel(12'(x), 12'(y));
            end
            drain();
        end

        $display("Sent %0d pixel items over 16 settings of size, mode, color and parity;",
                 items_sent);
        $display("checked %0d results, %0d of them outside the image.",
                 sb.checked, sb.outside_seen);
        if (sb.mismatches == 0 && sb.pending_px.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending_px.size());
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
